@@ sv/cssim_pkg.sv @@
// Shared types and constants for the streaming cosine similarity block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package cssim_pkg;

    // Width of each element field and of the similarity field.
    localparam int FIELD_W = 16;
    localparam int SIM_W = 16;

    // 1.0 in Q1.15.
    localparam int Q_ONE = 32768;

    // The quotient (dot^2 << 30) / (normA * normB) never exceeds 2^30.
    localparam int QUO_W = 31;
    // The first quotient bit comes from the load; the rest take one step each.
    localparam int DIV_STEPS = QUO_W - 1;
    localparam int SQRT_STEPS = SIM_W;

    // Multiplier digit consumed per cycle by the shared wide multiplier.
    localparam int DIG_W = 16;

    // Commands from the controller to the datapath, one cycle each.
    typedef struct packed {
        logic mul_load;   // load multiplicand and multiplier, clear the product
        logic mul_dot;    // with mul_load: square the dot product, else normA * normB
        logic mul_step;   // consume one multiplier digit
        logic p_store;    // keep the finished norm product as the divisor
        logic div_load;   // start the division from the finished dot square
        logic div_step;   // one quotient bit
        logic sqrt_load;  // start the root search
        logic sqrt_step;  // one root bit
        logic emit;       // write the result register and clear the accumulators
    } t_cmd;

endpackage

`default_nettype wire

@@ sv/cssim_if.sv @@
// Handshake interfaces for the element-pair input channel and the result channel.
// Depends on cssim_pkg for the field widths.
`default_nettype none

interface cssim_in_if;
    import cssim_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] elem_first;
    logic [FIELD_W-1:0] elem_second;
    logic               last;

    modport source (output valid, output elem_first, output elem_second, output last,
                    input ready);
    modport sink (input valid, input elem_first, input elem_second, input last,
                  output ready);
endinterface

interface cssim_res_if;
    import cssim_pkg::*;

    logic             valid;
    logic             ready;
    logic [SIM_W-1:0] similarity;
    logic             too_long;

    modport source (output valid, output similarity, output too_long, input ready);
    modport sink (input valid, input similarity, input too_long, output ready);
endinterface

`default_nettype wire

@@ sv/cssim_ctrl.sv @@
// Controller of the cosine similarity block: sequences accumulate, multiply,
// divide, root search and result write. Depends on cssim_pkg (t_cmd, step counts).
`default_nettype none

module cssim_ctrl #(
    parameter int N_MUL = 3
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_last,
    input  logic            i_out_free,
    output logic            o_ready,
    output cssim_pkg::t_cmd o_cmd
);
    import cssim_pkg::*;

    localparam int STEP_MAX = (N_MUL > DIV_STEPS) ?
                              ((N_MUL > SQRT_STEPS) ? N_MUL : SQRT_STEPS) :
                              ((DIV_STEPS > SQRT_STEPS) ? DIV_STEPS : SQRT_STEPS);
    localparam int STEP_W = (STEP_MAX > 1) ? $clog2(STEP_MAX) : 1;

    typedef enum logic [3:0] {
        S_ACCUM,
        S_DRAIN,
        S_LOAD_NN,
        S_MUL_NN,
        S_LOAD_DD,
        S_MUL_DD,
        S_DIV_LD,
        S_DIV,
        S_SQRT_LD,
        S_SQRT,
        S_EMIT
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_ready, n_ready;
    t_cmd              r_cmd, n_cmd;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ready = r_ready;
        n_cmd   = '0;
        case (r_state)
            S_ACCUM: begin
                if (i_in_valid && r_ready && i_in_last) begin
                    n_state = S_DRAIN;
                    n_ready = 1'b0;
                end
            end
            S_DRAIN: begin
                // The last beat's products land in the accumulators this cycle.
                n_state       = S_LOAD_NN;
                n_cmd.mul_load = 1'b1;
            end
            S_LOAD_NN: begin
                n_state        = S_MUL_NN;
                n_cmd.mul_step = 1'b1;
                n_cnt          = '0;
            end
            S_MUL_NN: begin
                if (r_cnt == STEP_W'(N_MUL - 1)) begin
                    n_state        = S_LOAD_DD;
                    n_cmd.p_store  = 1'b1;
                    n_cmd.mul_load = 1'b1;
                    n_cmd.mul_dot  = 1'b1;
                end else begin
                    n_cnt          = r_cnt + 1'b1;
                    n_cmd.mul_step = 1'b1;
                end
            end
            S_LOAD_DD: begin
                n_state        = S_MUL_DD;
                n_cmd.mul_step = 1'b1;
                n_cnt          = '0;
            end
            S_MUL_DD: begin
                if (r_cnt == STEP_W'(N_MUL - 1)) begin
                    n_state        = S_DIV_LD;
                    n_cmd.div_load = 1'b1;
                end else begin
                    n_cnt          = r_cnt + 1'b1;
                    n_cmd.mul_step = 1'b1;
                end
            end
            S_DIV_LD: begin
                n_state        = S_DIV;
                n_cmd.div_step = 1'b1;
                n_cnt          = '0;
            end
            S_DIV: begin
                if (r_cnt == STEP_W'(DIV_STEPS - 1)) begin
                    n_state         = S_SQRT_LD;
                    n_cmd.sqrt_load = 1'b1;
                end else begin
                    n_cnt          = r_cnt + 1'b1;
                    n_cmd.div_step = 1'b1;
                end
            end
            S_SQRT_LD: begin
                n_state         = S_SQRT;
                n_cmd.sqrt_step = 1'b1;
                n_cnt           = '0;
            end
            S_SQRT: begin
                if (r_cnt == STEP_W'(SQRT_STEPS - 1)) begin
                    n_state = S_EMIT;
                end else begin
                    n_cnt           = r_cnt + 1'b1;
                    n_cmd.sqrt_step = 1'b1;
                end
            end
            S_EMIT: begin
                // Wait until the result register is free, then reopen the input.
                if (i_out_free) begin
                    n_state    = S_ACCUM;
                    n_cmd.emit = 1'b1;
                    n_ready    = 1'b1;
                end
            end
            default: begin
                n_state = S_ACCUM;
                n_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCUM;
            r_cnt   <= '0;
            r_ready <= 1'b1;
            r_cmd   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ready <= n_ready;
            r_cmd   <= n_cmd;
        end
    end

    assign o_ready = r_ready;
    assign o_cmd   = r_cmd;

endmodule

`default_nettype wire

@@ sv/cssim_dp.sv @@
// Datapath of the cosine similarity block: accumulators, digit-serial wide
// multiplier, restoring divider, root search and result register. Depends on cssim_pkg.
`default_nettype none

module cssim_dp #(
    parameter int MAX_LEN = 1024,
    parameter int EB      = 16,
    parameter int ACC_W   = 42,
    parameter int N_MUL   = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [cssim_pkg::FIELD_W-1:0]   i_elem_first,
    input  logic [cssim_pkg::FIELD_W-1:0]   i_elem_second,
    input  cssim_pkg::t_cmd                 i_cmd,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [cssim_pkg::SIM_W-1:0]     o_similarity,
    output logic                            o_too_long,
    output logic                            o_out_free
);
    import cssim_pkg::*;

    localparam int PROD_W = 2 * EB;
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int MPL_W  = N_MUL * DIG_W;
    localparam int MUL_W  = ACC_W + MPL_W;
    localparam int WIDE_W = 2 * ACC_W;

    // ---------------- accumulation ----------------
    logic [EB-1:0]     elem_a, elem_b;
    logic [CNT_W-1:0]  r_count, n_count, cnt_base;
    logic              r_ovf, n_ovf, ovf_base, room;
    logic              r_pv;
    logic [PROD_W-1:0] r_pab, r_paa, r_pbb;
    logic [ACC_W-1:0]  r_dot, r_na, r_nb;

    assign elem_a = i_elem_first[EB-1:0];
    assign elem_b = i_elem_second[EB-1:0];

    // A result write clears the counters in the same cycle a new beat may arrive.
    assign cnt_base = i_cmd.emit ? '0 : r_count;
    assign ovf_base = i_cmd.emit ? 1'b0 : r_ovf;
    assign room     = cnt_base < CNT_W'(MAX_LEN);

    always_comb begin
        n_count = cnt_base;
        n_ovf   = ovf_base;
        if (i_accept) begin
            if (room) begin
                n_count = cnt_base + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_pv    <= 1'b0;
            r_dot   <= '0;
            r_na    <= '0;
            r_nb    <= '0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_pv    <= i_accept && room;
            r_dot   <= (i_cmd.emit ? '0 : r_dot) + (r_pv ? ACC_W'(r_pab) : '0);
            r_na    <= (i_cmd.emit ? '0 : r_na) + (r_pv ? ACC_W'(r_paa) : '0);
            r_nb    <= (i_cmd.emit ? '0 : r_nb) + (r_pv ? ACC_W'(r_pbb) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pab <= PROD_W'(elem_a) * PROD_W'(elem_b);
        r_paa <= PROD_W'(elem_a) * PROD_W'(elem_a);
        r_pbb <= PROD_W'(elem_b) * PROD_W'(elem_b);
    end

    // ---------------- wide multiplier, one digit per cycle ----------------
    logic [ACC_W-1:0]       r_mcand;
    logic [MPL_W-1:0]       r_mplier;
    logic [MUL_W-1:0]       r_prod;
    logic [WIDE_W-1:0]      r_p;
    logic [ACC_W+DIG_W-1:0] pp;

    // Most significant digit first, so the running product shifts left.
    assign pp = r_mcand * r_mplier[MPL_W-1 -: DIG_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load) begin
            r_mcand  <= i_cmd.mul_dot ? r_dot : r_na;
            r_mplier <= MPL_W'(i_cmd.mul_dot ? r_dot : r_nb);
            r_prod   <= '0;
        end else if (i_cmd.mul_step) begin
            r_mplier <= r_mplier << DIG_W;
            r_prod   <= {r_prod[MUL_W-DIG_W-1:0], {DIG_W{1'b0}}} + MUL_W'(pp);
        end
        if (i_cmd.p_store) begin
            r_p <= r_prod[WIDE_W-1:0];
        end
    end

    // ---------------- restoring divider: (dot^2 << 30) / (normA*normB) ----------------
    logic [WIDE_W-1:0] r_rem;
    logic [QUO_W-1:0]  r_quo;
    logic [WIDE_W:0]   div_t, div_diff;
    logic              div_ge;

    // The remainder stays below the divisor, so one extra bit covers the shift.
    assign div_t    = i_cmd.div_load ? {1'b0, r_prod[WIDE_W-1:0]} : {r_rem, 1'b0};
    assign div_ge   = div_t >= {1'b0, r_p};
    assign div_diff = div_t - {1'b0, r_p};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load || i_cmd.div_step) begin
            r_rem <= div_ge ? div_diff[WIDE_W-1:0] : div_t[WIDE_W-1:0];
        end
        if (i_cmd.div_load) begin
            r_quo <= QUO_W'(div_ge);
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[QUO_W-2:0], div_ge};
        end
    end

    // ---------------- root search, one bit per cycle ----------------
    logic [SIM_W-1:0]   r_q, r_bit, cand;
    logic [2*SIM_W-1:0] cand_sq;
    logic               cand_ok;

    assign cand    = r_q | r_bit;
    assign cand_sq = (2*SIM_W)'(cand) * (2*SIM_W)'(cand);
    assign cand_ok = (cand <= SIM_W'(Q_ONE)) && (cand_sq <= (2*SIM_W)'(r_quo));

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_load) begin
            r_q   <= '0;
            r_bit <= {1'b1, {(SIM_W-1){1'b0}}};
        end else if (i_cmd.sqrt_step) begin
            if (cand_ok) begin
                r_q <= cand;
            end
            r_bit <= r_bit >> 1;
        end
    end

    // ---------------- result register ----------------
    logic             r_out_valid;
    logic [SIM_W-1:0] r_sim;
    logic             r_too;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            // A zero norm makes the cosine undefined; it is reported as zero.
            r_sim <= ((r_na == '0) || (r_nb == '0)) ? '0 : r_q;
            r_too <= r_ovf;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_similarity = r_sim;
    assign o_too_long   = r_too;
    assign o_out_free   = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

@@ sv/cosine_similarity_stream_top.sv @@
// Top level of the streaming cosine similarity block: controller plus datapath.
// Depends on cssim_pkg, cssim_if, cssim_ctrl and cssim_dp.
`default_nettype none

// Element pairs are taken one beat per cycle while the vectors stream in. The beat
// marked last closes the vectors: the input then stalls while the result is worked
// out by a digit-serial multiplier (normA*normB, then dot^2, ceil(ACC_W/16) digits
// of 16 bits each, ACC_W being the accumulator width), a restoring divider giving
// one quotient bit a cycle (31 bits) and a square-root search giving one result bit
// a cycle (16 bits). A finished result waits in an output register, so the next
// vectors may start streaming before it is taken.
// Pairs past MAX_LEN are dropped and flagged with too_long on the result.

module cosine_similarity_stream_top #(
    parameter int MAX_LEN   = 1024,
    parameter int ELEM_BITS = 16
) (
    input logic           i_clk,
    input logic           i_rst_n,
    cssim_in_if.sink      i_in,
    cssim_res_if.source   o_res
);
    import cssim_pkg::*;

    localparam int EB    = (ELEM_BITS < FIELD_W) ? ELEM_BITS : FIELD_W;
    localparam int ACC_W = 2 * EB + $clog2(MAX_LEN);
    localparam int N_MUL = (ACC_W + DIG_W - 1) / DIG_W;

    logic ready;
    logic accept;
    logic out_free;
    t_cmd cmd;

    assign i_in.ready = ready;
    assign accept     = i_in.valid && ready;

    cssim_ctrl #(
        .N_MUL (N_MUL)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last),
        .i_out_free (out_free),
        .o_ready    (ready),
        .o_cmd      (cmd)
    );

    cssim_dp #(
        .MAX_LEN (MAX_LEN),
        .EB      (EB),
        .ACC_W   (ACC_W),
        .N_MUL   (N_MUL)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_elem_first  (i_in.elem_first),
        .i_elem_second (i_in.elem_second),
        .i_cmd         (cmd),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_similarity  (o_res.similarity),
        .o_too_long    (o_res.too_long),
        .o_out_free    (out_free)
    );

endmodule

`default_nettype wire

@@ sv/cssim_checker.sv @@
// Port-level checks for the cosine similarity block, bound to its top level.
// Depends on cssim_pkg and cosine_similarity_stream_top.
`default_nettype none

module cssim_sva (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_in_last,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic [cssim_pkg::SIM_W-1:0]   i_res_similarity,
    input logic                          i_res_too_long
);
    import cssim_pkg::*;

    // The block must stop taking beats once the vectors are closed.
    a_stall_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last) |=> !i_in_ready)
        else $error("input still ready after the last beat");

    // A cosine of non-negative vectors never exceeds 1.0.
    a_sim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_similarity <= SIM_W'(Q_ONE)))
        else $error("similarity above 1.0");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> i_res_valid)
        else $error("result beat dropped before it was taken");

    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
        ($stable(i_res_similarity) && $stable(i_res_too_long)))
        else $error("stalled result beat changed");

endmodule

bind cosine_similarity_stream_top cssim_sva u_cssim_sva (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_last        (i_in.last),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_similarity (o_res.similarity),
    .i_res_too_long   (o_res.too_long)
);

`default_nettype wire

@@ verif/cssim_checker.sv @@
// Checker for the streaming cosine similarity block: watches both channels, predicts each
// result from the accepted element pairs and compares it with the result beats.
// Depends on cssim_pkg and the handshake interfaces in cssim_if.
`default_nettype none

module cssim_checker #(
    parameter int MAX_LEN   = 1024,
    parameter int ELEM_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cssim_in_if   i_in,
    cssim_res_if  i_res,
    output int    o_fail_count,
    output int    o_pending
);
    import cssim_pkg::*;

    localparam logic [FIELD_W-1:0] ELEM_MASK = FIELD_W'((64'd1 << ELEM_BITS) - 1);

    typedef struct packed {
        logic [SIM_W-1:0] similarity;
        logic             too_long;
    } t_sim_result;

    t_sim_result expected_sims[$];
    t_sim_result want;

    logic [63:0]        dot_acc;
    logic [63:0]        norm_first_acc;
    logic [63:0]        norm_second_acc;
    int                 pair_count;
    logic               overflow_seen;
    logic [FIELD_W-1:0] elem_a;
    logic [FIELD_W-1:0] elem_b;

    // Largest q in 0..1.0 with q*q*normA*normB <= (1.0*dot)^2, found one bit at a time.
    function automatic logic [SIM_W-1:0] cosine_q15(input logic [63:0] dot,
                                                    input logic [63:0] norm_a,
                                                    input logic [63:0] norm_b);
        logic [127:0] norm_prod;
        logic [127:0] dot_scaled;
        logic [127:0] trial;
        logic [16:0]  q;
        logic [16:0]  cand;
        int           bit_idx;
        if (norm_a == 0 || norm_b == 0) begin
            return '0;
        end
        norm_prod = 128'(norm_a) * 128'(norm_b);
        dot_scaled = 128'(dot) * 128'(dot) * 128'(Q_ONE) * 128'(Q_ONE);
        q = '0;
        for (bit_idx = SIM_W - 1; bit_idx >= 0; bit_idx--) begin
            cand = q | (17'd1 << bit_idx);
            if (cand <= 17'(Q_ONE)) begin
                trial = 128'(cand) * 128'(cand) * norm_prod;
                if (trial <= dot_scaled) begin
                    q = cand;
                end
            end
        end
        return q[SIM_W-1:0];
    endfunction

    task automatic report_failure(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dot_acc <= '0;
            norm_first_acc <= '0;
            norm_second_acc <= '0;
            pair_count <= 0;
            overflow_seen <= 1'b0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (expected_sims.size() == 0) begin
                    report_failure($sformatf(
                        "result beat with nothing expected: sim %0d too_long %0b",
                        i_res.similarity, i_res.too_long));
                end else begin
                    want = expected_sims.pop_front();
                    if (i_res.similarity !== want.similarity) begin
                        report_failure($sformatf("similarity expected %0d, got %0d",
                                                 want.similarity, i_res.similarity));
                    end
                    if (i_res.too_long !== want.too_long) begin
                        report_failure($sformatf("too_long expected %0b, got %0b",
                                                 want.too_long, i_res.too_long));
                    end
                end
            end

            if (i_in.valid && i_in.ready) begin
                elem_a = i_in.elem_first & ELEM_MASK;
                elem_b = i_in.elem_second & ELEM_MASK;
                // Pairs past MAX_LEN only raise the flag; the sums keep the first MAX_LEN.
                if (i_in.last) begin
                    if (pair_count < MAX_LEN) begin
                        want.similarity = cosine_q15(dot_acc + 64'(elem_a) * 64'(elem_b),
                                                     norm_first_acc + 64'(elem_a) * 64'(elem_a),
                                                     norm_second_acc + 64'(elem_b) * 64'(elem_b));
                        want.too_long = overflow_seen;
                    end else begin
                        want.similarity = cosine_q15(dot_acc, norm_first_acc, norm_second_acc);
                        want.too_long = 1'b1;
                    end
                    expected_sims = {expected_sims, want};
                    dot_acc <= '0;
                    norm_first_acc <= '0;
                    norm_second_acc <= '0;
                    pair_count <= 0;
                    overflow_seen <= 1'b0;
                end else if (pair_count < MAX_LEN) begin
                    dot_acc <= dot_acc + 64'(elem_a) * 64'(elem_b);
                    norm_first_acc <= norm_first_acc + 64'(elem_a) * 64'(elem_a);
                    norm_second_acc <= norm_second_acc + 64'(elem_b) * 64'(elem_b);
                    pair_count <= pair_count + 1;
                end else begin
                    overflow_seen <= 1'b1;
                end
            end
            o_pending = expected_sims.size();
        end
    end

endmodule

`default_nettype wire

@@ verif/tb_cosine_similarity_stream_top.sv @@
// Testbench top for the streaming cosine similarity block: drives element-pair vectors,
// throttles the result channel and gives the verdict from the checker's failure count.
// Depends on cssim_pkg, cssim_if, cssim_checker and the block's RTL.
`default_nettype none

module tb_cosine_similarity_stream_top;
    import cssim_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 11;
    localparam int MAX_LEN        = 1024;
    localparam int ELEM_BITS      = 16;
    localparam int RANDOM_ITEMS   = 890;
    localparam int CALM_TAIL      = 300;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 70;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic [FIELD_W-1:0] ELEM_MAX = '1;

    typedef enum int {
        MIX_UNIFORM,
        MIX_SMALL,
        MIX_PARALLEL,
        MIX_SPARSE,
        MIX_ONE_ZERO,
        MIX_EXTREME
    } t_mix;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    bit   quiet = 1'b0;
    bit   tx_calm = 1'b0;
    bit   rx_calm = 1'b0;
    bit   hold_req = 1'b0;
    bit   hold_served = 1'b0;

    cssim_in_if  in_ch ();
    cssim_res_if res_ch ();

    always #HALF_PERIOD i_clk = ~i_clk;

    cosine_similarity_stream_top #(
        .MAX_LEN   (MAX_LEN),
        .ELEM_BITS (ELEM_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    cssim_checker #(
        .MAX_LEN   (MAX_LEN),
        .ELEM_BITS (ELEM_BITS)
    ) chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic send_pair(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b,
                             input logic is_last);
        int gap;
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.elem_first <= a;
        in_ch.elem_second <= b;
        in_ch.last <= is_last;
        do @(posedge i_clk); while (!in_ch.ready);
        if (!quiet && !tx_calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            repeat (gap) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
            end
        end
    endtask

    task automatic send_vector(input int len, input t_mix mix);
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        int                 scale;
        bit                 swap_zero;
        scale = $urandom_range(1, 255);
        swap_zero = ($urandom_range(0, 1) == 1);
        for (int idx = 0; idx < len; idx++) begin
            case (mix)
                MIX_UNIFORM: begin
                    a = FIELD_W'($urandom);
                    b = FIELD_W'($urandom);
                end
                MIX_SMALL: begin
                    a = FIELD_W'($urandom_range(0, 3));
                    b = FIELD_W'($urandom_range(0, 3));
                end
                MIX_PARALLEL: begin
                    // Scaled copies give a cosine of one, or just below after a nudge.
                    a = FIELD_W'($urandom_range(0, 255));
                    b = FIELD_W'(a * scale + (($urandom_range(0, 7) == 0) ? 1 : 0));
                end
                MIX_SPARSE: begin
                    a = ($urandom_range(0, 3) == 0) ? FIELD_W'($urandom) : '0;
                    b = ($urandom_range(0, 3) == 0) ? FIELD_W'($urandom) : '0;
                end
                MIX_ONE_ZERO: begin
                    a = swap_zero ? '0 : FIELD_W'($urandom);
                    b = swap_zero ? FIELD_W'($urandom) : '0;
                end
                default: begin
                    a = $urandom_range(0, 1) ? ELEM_MAX : '0;
                    b = $urandom_range(0, 1) ? ELEM_MAX : '0;
                end
            endcase
            send_pair(a, b, idx == len - 1);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        wait (pending == 0);
    endtask

    // Result side: short random stalls, calm stretches, and one long hold-off on request.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 199) == 0) begin
                rx_calm = ~rx_calm;
            end
            if (hold_req && !hold_served) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_served = 1'b1;
            end else if (!quiet && !rx_calm && $urandom_range(0, 3) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int   sent;
        int   len;
        t_mix mix;

        in_ch.valid = 1'b0;
        in_ch.elem_first = '0;
        in_ch.elem_second = '0;
        in_ch.last = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Single-pair vectors: extremes, and each zero-norm combination.
        send_pair(ELEM_MAX, ELEM_MAX, 1'b1);
        send_pair('0, '0, 1'b1);
        send_pair('0, ELEM_MAX, 1'b1);
        send_pair(ELEM_MAX, '0, 1'b1);
        send_pair(16'd1, ELEM_MAX, 1'b1);
        // Orthogonal, nearly orthogonal, a known fraction, parallel, and a zero second norm.
        send_pair(16'd1, '0, 1'b0);
        send_pair('0, 16'd1, 1'b1);
        send_pair(ELEM_MAX, 16'd1, 1'b0);
        send_pair(16'd1, ELEM_MAX, 1'b1);
        send_pair(16'd3, 16'd4, 1'b0);
        send_pair(16'd4, 16'd3, 1'b1);
        send_pair(16'd1, 16'd2, 1'b0);
        send_pair(16'd2, 16'd4, 1'b0);
        send_pair(16'd3, 16'd6, 1'b1);
        send_pair('0, '0, 1'b0);
        send_pair(16'd5, '0, 1'b1);
        send_pair(16'hAAAA, 16'h5555, 1'b0);
        send_pair(16'h5555, 16'hAAAA, 1'b1);

        // Too long: full-scale sums over MAX_LEN pairs, then a dropped pair that would
        // pull the cosine below one if it were counted.
        repeat (MAX_LEN) send_pair(ELEM_MAX, ELEM_MAX, 1'b0);
        send_pair(ELEM_MAX, '0, 1'b1);

        // Hold off the result side while vectors keep coming, so the input backs up.
        hold_req = 1'b1;
        repeat (6) send_vector(3, MIX_UNIFORM);
        wait (hold_served);
        drain_results();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                len = $urandom_range(9, 40);
            end else begin
                len = $urandom_range(1, 8);
            end
            mix = t_mix'($urandom_range(MIX_UNIFORM, MIX_EXTREME));
            tx_calm = ($urandom_range(0, 3) == 0);
            send_vector(len, mix);
            sent += len;
            if (sent >= RANDOM_ITEMS - CALM_TAIL) begin
                quiet = 1'b1;
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ cosine_similarity_stream_top.f @@
sv/cssim_pkg.sv
sv/cssim_if.sv
sv/cssim_ctrl.sv
sv/cssim_dp.sv
sv/cosine_similarity_stream_top.sv
sv/cssim_checker.sv
verif/cssim_checker.sv
verif/tb_cosine_similarity_stream_top.sv
